[sv/swa_pkg.sv]
// Shared types and constants of the sliding window average core.
package swa_pkg;

  localparam int TIME_W    = 63;
  localparam int VALUE_W   = 32;
  localparam int SUM_W     = 38;
  localparam int MEAN_W    = 40;
  localparam int MEAN_FRAC = 8;
  localparam int CFG_W     = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ADD,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[sv/swa_div.sv]
// Bit-serial restoring divider for unsigned operands, one quotient bit per cycle.
module swa_div import swa_pkg::*; #(
  parameter int DW = 46,
  parameter int NW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output div_status_t   status
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   dvd;
  logic [NW-1:0]   rem;
  logic [NW-1:0]   dsr;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            done;

  logic [NW:0]   trial;
  logic [NW:0]   diff;
  logic          fits;
  logic [NW-1:0] rem_step;

  // The remainder stays below the divisor, so the shifted trial fits in NW+1 bits.
  always_comb begin
    trial    = {rem, dvd[DW-1]};
    fits     = trial >= {1'b0, dsr};
    diff     = trial - {1'b0, dsr};
    rem_step = fits ? diff[NW-1:0] : trial[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNTW'(DW);
    end else if (busy) begin
      cnt <= cnt - CNTW'(1);
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Quotient bits shift in at the bottom as dividend bits leave at the top.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[DW-2:0], fits};
      rem <= rem_step;
    end
  end

  assign quotient    = dvd;
  assign status.busy = busy;
  assign status.done = done;

endmodule

[sv/sliding_window_average_core.sv]
// Top level of the sliding window average core: window store, sum and sequencer.
//
// Samples enter on the sample channel (sample_valid, sample_ready, sample_time,
// sample_value) and results leave on the result channel (result_valid,
// result_ready, middle_time, window_sum, window_mean). A word moves on a channel
// at a rising edge where its valid and ready are both high.
// The block takes one sample at a time. A sample that does not yet complete a
// window passes the read and add states and gives no result. A sample that
// completes a window passes the read and add states (store write and sum
// update), the divider start, the bit-serial divider over a dividend of sum
// width plus eight bits (46 with MAX_WINDOW = 64) and the done state, which
// loads the result register; the next sample can be taken after that.
// sample_ready is high only between samples.
// The result sits in its own register, so the next sample is accepted while the
// previous result waits. If the receiver still stalls when the next result is
// ready, the sequencer holds it until the register frees up.
// Writing cfg_data with cfg_write high sets the window size and restarts the fill;
// size zero acts as one and sizes above MAX_WINDOW saturate. The user must make
// writes only while the block is idle; the block does not enforce it. Synchronous
// reset sets the size to five, clears sum, fill count and write pointer, not the window store.
module sliding_window_average_core import swa_pkg::*; #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     sample_valid,
  output logic                     sample_ready,
  input  logic [TIME_W-1:0]        sample_time,
  input  logic signed [VALUE_W-1:0] sample_value,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic [TIME_W-1:0]        middle_time,
  output logic signed [SUM_W-1:0]  window_sum,
  output logic signed [MEAN_W-1:0] window_mean
);

  // Pointer width, exact sum width, divider width, the width of address math and the sum extension width.
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SW = VALUE_W + $clog2(MAX_WINDOW);
  localparam int DW = SW + MEAN_FRAC;
  localparam int CW = ((AW > CFG_W) ? AW : CFG_W) + 1;
  localparam int XW = (SW > SUM_W) ? SW : SUM_W;

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0]         window_size;
  logic [CFG_W-1:0]         n;
  logic [CFG_W-1:0]         fill;
  logic [AW-1:0]            wp;
  logic signed [SW-1:0]     sum;
  logic [TIME_W-1:0]        time_hold;
  logic signed [VALUE_W-1:0] value_hold;
  logic                     neg;

  // Window store: one write per sample, at most one registered read per ring and item.
  logic signed [VALUE_W-1:0] value_ring [MAX_WINDOW];
  logic [TIME_W-1:0]         time_ring  [MAX_WINDOW];
  logic signed [VALUE_W-1:0] value_rd;
  logic [TIME_W-1:0]         time_rd;

  logic          accept;
  logic          full;
  logic [CW-1:0] back_x;
  logic [CW-1:0] mid_sum;
  logic [CW-1:0] mid_x;
  logic [AW-1:0] back;
  logic [AW-1:0] mid;

  logic [SW-1:0]        sum_mag;
  logic [DW-1:0]        dividend;
  logic [DW-1:0]        quotient;
  logic [DW-1:0]        mean_full;
  logic signed [XW-1:0] sum_x;
  logic                 div_start;
  logic                 out_free;
  div_status_t          div_st;

  assign accept       = sample_valid && sample_ready;
  assign sample_ready = (state == S_IDLE);
  assign full         = fill >= n;
  assign out_free     = !result_valid || result_ready;
  assign div_start    = (state == S_PREP);

  // Effective window size: zero means one, anything above the store saturates.
  always_comb begin
    if (window_size == '0) begin
      n = CFG_W'(1);
    end else if (int'(window_size) > MAX_WINDOW) begin
      n = CFG_W'(MAX_WINDOW);
    end else begin
      n = window_size;
    end
  end

  // The slot n places behind the write pointer. Before the write it is the
  // sample leaving the window; after the pointer moves it is the oldest sample.
  always_comb begin
    if (CW'(wp) >= CW'(n)) begin
      back_x = CW'(wp) - CW'(n);
    end else begin
      back_x = CW'(wp) + CW'(MAX_WINDOW) - CW'(n);
    end
    mid_sum = back_x + CW'(n >> 1);
    if (mid_sum >= CW'(MAX_WINDOW)) begin
      mid_x = mid_sum - CW'(MAX_WINDOW);
    end else begin
      mid_x = mid_sum;
    end
    back = back_x[AW-1:0];
    mid  = mid_x[AW-1:0];
  end

  // The divider works on the magnitude; the sign is put back on the quotient,
  // which gives truncation toward zero.
  always_comb begin
    sum_mag   = sum[SW-1] ? (~sum + SW'(1)) : sum;
    dividend  = {sum_mag, {MEAN_FRAC{1'b0}}};
    mean_full = neg ? (~quotient + DW'(1)) : quotient;
    sum_x     = XW'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_ADD;
      S_ADD: begin
        // The fill count has already been advanced here.
        if (full) begin
          state_next = S_PREP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_PREP: state_next = S_DIV;
      S_DIV: begin
        if (div_st.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Window control state. A size write restarts the fill in every case.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= CFG_RESET;
      fill        <= '0;
      wp          <= '0;
      sum         <= '0;
    end else if (cfg_write) begin
      window_size <= cfg_data;
      fill        <= '0;
      wp          <= '0;
      sum         <= '0;
    end else begin
      case (state)
        S_READ: begin
          if (full) begin
            sum <= sum - SW'(value_rd);
          end else begin
            fill <= fill + CFG_W'(1);
          end
          if (int'(wp) == MAX_WINDOW - 1) begin
            wp <= '0;
          end else begin
            wp <= wp + AW'(1);
          end
        end
        S_ADD: sum <= sum + SW'(value_hold);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      time_hold  <= sample_time;
      value_hold <= sample_value;
    end
    if (state == S_PREP) begin
      neg <= sum[SW-1];
    end
  end

  // Ring write and reads. The leaving value is read before its slot is reused.
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      value_ring[wp] <= value_hold;
      time_ring[wp]  <= time_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_rd <= value_ring[back];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      time_rd <= time_ring[mid];
    end
  end

  swa_div #(
    .DW(DW),
    .NW(CFG_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (n),
    .quotient (quotient),
    .status   (div_st)
  );

  // Result register: loaded from the sequencer, emptied by the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      middle_time <= time_rd;
      window_sum  <= sum_x[SUM_W-1:0];
      window_mean <= mean_full[MEAN_W-1:0];
    end
  end

  // The fill count never passes the effective window size.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= n)
    else $error("fill count exceeds window size");

  // The write pointer stays inside the store.
  a_wp_bound: assert property (@(posedge clk) disable iff (rst) int'(wp) < MAX_WINDOW)
    else $error("write pointer outside the window store");

  // A result is only prepared for a complete window.
  a_prep_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREP) |-> (fill == n))
    else $error("result prepared for an incomplete window");

  // Starting the divider makes it busy in the next cycle.
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (div_st.busy && !div_st.done))
    else $error("divider did not start");

  // The sequencer only leaves the divide state once the divider is idle.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_st.done) |-> !div_st.busy)
    else $error("divider reported done while busy");

endmodule
